[hw/rtl/assert_macros.svh]
// assertion macros shared by the light range unit
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, off during reset
`define ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[hw/rtl/lar_pkg.sv]
// types and constants of the light range unit
// no dependencies
`default_nettype none

package lar_pkg;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_ROOT = 2'd1;
    localparam logic [1:0] ST_NEG     = 2'd2;

    // target width, right side width, polynomial accumulator width
    localparam int TW = 36;
    localparam int RW = TW + 32;
    localparam int PW = 100;

    // one item in the root search
    typedef struct packed {
        logic          done;
        logic [1:0]    status;
        logic [31:0]   cap;
        logic [31:0]   q;
        logic [31:0]   l;
        logic [RW-1:0] rhs;
        logic [31:0]   x;
        logic [63:0]   qx;
        logic [PW-1:0] p;
    } lar_stage_t;

endpackage

`default_nettype wire

[hw/rtl/lar_front.sv]
// front end: magnitudes, target, case selection (three stages)
// depends on lar_pkg
`default_nettype none

module lar_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [31:0]       att_constant,
    input  wire logic [31:0]       att_linear,
    input  wire logic [31:0]       att_quadratic,
    input  wire logic [15:0]       colour_red,
    input  wire logic [15:0]       colour_green,
    input  wire logic [15:0]       colour_blue,
    input  wire logic [15:0]       diffuse_gain,
    input  wire logic [31:0]       distance_cap,
    output logic                   out_valid,
    output lar_pkg::lar_stage_t    out_data
);

    function automatic logic [31:0] mag(input logic [31:0] v);
        mag = v[31] ? (~v + 32'd1) : v;
    endfunction

    logic        a_valid_reg;
    logic [31:0] a_kc_reg, a_lc_reg, a_qc_reg, a_cap_reg;
    logic [lar_pkg::TW-1:0] a_target_reg;
    logic [15:0] peak;
    logic [31:0] prod;

    // stage a: magnitudes and target
    always_comb
    begin
        peak = colour_red;
        if (colour_green > peak)
        begin
            peak = colour_green;
        end
        if (colour_blue > peak)
        begin
            peak = colour_blue;
        end
        prod = {16'b0, peak} * {16'b0, diffuse_gain};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_kc_reg     <= mag(att_constant);
            a_lc_reg     <= mag(att_linear);
            a_qc_reg     <= mag(att_quadratic);
            a_cap_reg    <= distance_cap;
            a_target_reg <= {prod, 4'b0};
        end
    end

    // stage b: deficit products and difference
    logic        b_valid_reg;
    logic [31:0] b_lc_reg, b_qc_reg, b_cap_reg;
    logic        b_none_reg, b_lt_reg;
    logic [63:0] b_lsq_reg;
    logic [66:0] b_neg_reg;
    logic [lar_pkg::TW-1:0] b_diff_reg;
    logic [lar_pkg::TW-1:0] kc_ext;
    logic        lt;
    logic [31:0] deficit;

    always_comb
    begin
        kc_ext  = {{(lar_pkg::TW-32){1'b0}}, a_kc_reg};
        lt      = a_target_reg < kc_ext;
        deficit = 32'(kc_ext - a_target_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_lc_reg   <= a_lc_reg;
            b_qc_reg   <= a_qc_reg;
            b_cap_reg  <= a_cap_reg;
            b_none_reg <= (a_lc_reg == 32'd0) && (a_qc_reg == 32'd0);
            b_lt_reg   <= lt;
            b_lsq_reg  <= {32'b0, a_lc_reg} * {32'b0, a_lc_reg};
            b_neg_reg  <= {33'b0, a_qc_reg, 2'b0} * {35'b0, deficit};
            b_diff_reg <= a_target_reg - kc_ext;
        end
    end

    // stage c: pick the case, seed the root search
    lar_pkg::lar_stage_t c_next;

    always_comb
    begin
        c_next        = '0;
        c_next.cap    = b_cap_reg;
        c_next.q      = b_qc_reg;
        c_next.l      = b_lc_reg;
        c_next.rhs    = {b_diff_reg, 32'b0};
        c_next.status = lar_pkg::ST_OK;
        if (b_none_reg)
        begin
            c_next.done = 1'b1;
            c_next.x    = b_cap_reg;
        end
        else if (b_lt_reg)
        begin
            c_next.done = 1'b1;
            if (b_qc_reg != 32'd0 && b_lc_reg == 32'd0)
            begin
                c_next.x      = b_cap_reg;
                c_next.status = lar_pkg::ST_NO_ROOT;
            end
            else if (b_qc_reg != 32'd0 && b_neg_reg > {3'b0, b_lsq_reg})
            begin
                c_next.x      = b_cap_reg;
                c_next.status = lar_pkg::ST_NO_ROOT;
            end
            else
            begin
                c_next.x      = 32'd0;
                c_next.status = lar_pkg::ST_NEG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data <= c_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lar_root_stage.sv]
// one bit of the root search, polynomial kept incrementally
// depends on lar_pkg
`default_nettype none

module lar_root_stage #(
    parameter int BIT = 31
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire lar_pkg::lar_stage_t in_data,
    output logic                   out_valid,
    output lar_pkg::lar_stage_t    out_data
);

    logic [31:0]            tryx;
    logic [lar_pkg::PW-1:0] cand;
    logic                   take;
    lar_pkg::lar_stage_t    nxt;

    // p(x + 2^b) = p(x) + q*x*2^(b+1) + q*2^(2b) + l*2^(b+16)
    always_comb
    begin
        tryx = in_data.x | (32'd1 << BIT);
        cand = in_data.p
             + ({{(lar_pkg::PW-64){1'b0}}, in_data.qx} << (BIT + 1))
             + ({{(lar_pkg::PW-32){1'b0}}, in_data.q} << (2 * BIT))
             + ({{(lar_pkg::PW-32){1'b0}}, in_data.l} << (BIT + 16));
        take = !in_data.done && (tryx <= in_data.cap)
             && (cand <= {{(lar_pkg::PW-lar_pkg::RW){1'b0}}, in_data.rhs});
        nxt  = in_data;
        if (take)
        begin
            nxt.x  = tryx;
            nxt.p  = cand;
            nxt.qx = in_data.qx + ({32'b0, in_data.q} << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data <= nxt;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/light_attenuation_range_unit.sv]
// top level of the light range unit
// depends on lar_pkg, lar_front, lar_root_stage, assert_macros.svh
`default_nettype none

// Takes one light per cycle while in_ready is high and returns the distance,
// Q16.16 and never above distance_cap, at which the attenuated light falls to
// 1/256 of its peak channel. The pipe has three front stages (magnitudes and
// target, deficit products, case choice) and one stage per result bit of the
// restoring root search, each an add-and-compare on a running polynomial.
// The whole pipe advances together; it holds while a result waits and
// out_ready is low, so in_ready follows out_ready combinationally.
`include "assert_macros.svh"

module light_attenuation_range_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] att_constant,
    input  wire logic [31:0] att_linear,
    input  wire logic [31:0] att_quadratic,
    input  wire logic [15:0] colour_red,
    input  wire logic [15:0] colour_green,
    input  wire logic [15:0] colour_blue,
    input  wire logic [15:0] diffuse_gain,
    input  wire logic [31:0] distance_cap,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      range,
    output logic [1:0]       status
);

    logic                en;
    logic                vld [0:32];
    lar_pkg::lar_stage_t dat [0:32];

    // global advance
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    lar_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid),
        .att_constant  (att_constant),
        .att_linear    (att_linear),
        .att_quadratic (att_quadratic),
        .colour_red    (colour_red),
        .colour_green  (colour_green),
        .colour_blue   (colour_blue),
        .diffuse_gain  (diffuse_gain),
        .distance_cap  (distance_cap),
        .out_valid     (vld[0]),
        .out_data      (dat[0])
    );

    // root search, msb first
    for (genvar i = 0; i < 32; i++)
    begin : g_bit
        lar_root_stage #(.BIT(31 - i)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vld[i]),
            .in_data   (dat[i]),
            .out_valid (vld[i+1]),
            .out_data  (dat[i+1])
        );
    end

    assign out_valid = vld[32];
    assign range     = dat[32].x;
    assign status    = dat[32].status;

    // checks
    `ASSERT_IMPLY(a_neg_zero, clk, rst_n, out_valid && status == lar_pkg::ST_NEG,
        range == 32'd0, "negative clamp with non-zero range")
    `ASSERT_IMPLY(a_cap_bound, clk, rst_n, out_valid, range <= dat[32].cap,
        "range above cap")
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(range) && $stable(status), "stalled result changed")

endmodule

`default_nettype wire
